// ===== hdl/quaternion_product_assert.svh =====
// Assertion macros used by the quaternion product checker.
// Depends on nothing; included by the files that carry assertions.
`ifndef QUATERNION_PRODUCT_ASSERT_SVH
`define QUATERNION_PRODUCT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define QP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error(msg);

// Implication after a fixed number of cycles, disabled while reset is low.
`define QP_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |-> ##n (cons)) else $error(msg);

`endif

// ===== hdl/qp_pkg.sv =====
// Types and constants for the fixed-point quaternion product pipeline.
// No dependencies; imported by every module of the block.
package qp_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int ACC_W     = PROD_W + 3;
	localparam int NCOMP     = 4;
	localparam int NTERM     = 4;
	localparam int NPAIR     = 2;
	// cycles from an accepted start to the edge that takes the result
	localparam int LATENCY   = 4;

	// component slots
	localparam int CX = 0;
	localparam int CY = 1;
	localparam int CZ = 2;
	localparam int CW = 3;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

	typedef logic signed [DATA_W-1:0] comp_t;

	typedef struct packed {
		comp_t p_x;
		comp_t p_y;
		comp_t p_z;
		comp_t p_w;
		comp_t q_x;
		comp_t q_y;
		comp_t q_z;
		comp_t q_w;
	} qp_in_t;

	typedef struct packed {
		comp_t r_x;
		comp_t r_y;
		comp_t r_z;
		comp_t r_w;
		logic  saturated;
	} qp_out_t;

	typedef logic [NTERM-1:0][PROD_W-1:0] term_vec_t;
	typedef term_vec_t [NCOMP-1:0]        prod_set_t;
	typedef logic [NPAIR-1:0][PAIR_W-1:0] pair_vec_t;
	typedef pair_vec_t [NCOMP-1:0]        pair_set_t;
	typedef logic [NCOMP-1:0][ACC_W-1:0]  acc_set_t;

endpackage

// ===== hdl/qp_mul.sv =====
// Product stage: the sixteen 32x32 signed component products, registered.
// Depends on qp_pkg.
module qp_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  qp_pkg::qp_in_t    operand,
	output logic              valid_s1,
	output qp_pkg::prod_set_t prod_s1
);
	import qp_pkg::*;

	// vector parts: scalar terms, then cross pair; w: ww, xx, yy, zz
	always_ff @(posedge clk) begin
		prod_s1[CX][0] <= PROD_W'(operand.p_w * operand.q_x);
		prod_s1[CX][1] <= PROD_W'(operand.q_w * operand.p_x);
		prod_s1[CX][2] <= PROD_W'(operand.p_y * operand.q_z);
		prod_s1[CX][3] <= PROD_W'(operand.p_z * operand.q_y);
		prod_s1[CY][0] <= PROD_W'(operand.p_w * operand.q_y);
		prod_s1[CY][1] <= PROD_W'(operand.q_w * operand.p_y);
		prod_s1[CY][2] <= PROD_W'(operand.p_z * operand.q_x);
		prod_s1[CY][3] <= PROD_W'(operand.p_x * operand.q_z);
		prod_s1[CZ][0] <= PROD_W'(operand.p_w * operand.q_z);
		prod_s1[CZ][1] <= PROD_W'(operand.q_w * operand.p_z);
		prod_s1[CZ][2] <= PROD_W'(operand.p_x * operand.q_y);
		prod_s1[CZ][3] <= PROD_W'(operand.p_y * operand.q_x);
		prod_s1[CW][0] <= PROD_W'(operand.p_w * operand.q_w);
		prod_s1[CW][1] <= PROD_W'(operand.p_x * operand.q_x);
		prod_s1[CW][2] <= PROD_W'(operand.p_y * operand.q_y);
		prod_s1[CW][3] <= PROD_W'(operand.p_z * operand.q_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

endmodule

// ===== hdl/qp_sum.sv =====
// Accumulate stages: pairwise sums, then the full sum plus the rounding half.
// Depends on qp_pkg.
module qp_sum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  qp_pkg::prod_set_t prod_s1,
	output logic              valid_s3,
	output qp_pkg::acc_set_t  total_s3
);
	import qp_pkg::*;

	pair_set_t pair_s2;
	logic      valid_s2;

	function automatic logic signed [PAIR_W-1:0] ext(input logic [PROD_W-1:0] v);
		ext = PAIR_W'($signed(v));
	endfunction

	// stage 2: vector parts take a + b and c - d; scalar takes a - b and -(c + d)
	always_ff @(posedge clk) begin
		for (int c = 0; c < NCOMP - 1; c++) begin
			pair_s2[c][0] <= ext(prod_s1[c][0]) + ext(prod_s1[c][1]);
			pair_s2[c][1] <= ext(prod_s1[c][2]) - ext(prod_s1[c][3]);
		end
		pair_s2[CW][0] <= ext(prod_s1[CW][0]) - ext(prod_s1[CW][1]);
		pair_s2[CW][1] <= -ext(prod_s1[CW][2]) - ext(prod_s1[CW][3]);
	end

	// stage 3: exact total with the rounding half folded in
	always_ff @(posedge clk) begin
		for (int c = 0; c < NCOMP; c++) begin
			total_s3[c] <= ACC_W'($signed(pair_s2[c][0])) + ACC_W'($signed(pair_s2[c][1]))
				+ RND_HALF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

endmodule

// ===== hdl/qp_round.sv =====
// Output stage: drop the fraction bits, clamp each component, flag clipping.
// Depends on qp_pkg.
module qp_round (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s3,
	input  qp_pkg::acc_set_t total_s3,
	output logic             valid_s4,
	output qp_pkg::qp_out_t  result_s4
);
	import qp_pkg::*;

	comp_t            clip  [NCOMP];
	logic [NCOMP-1:0] over;

	// arithmetic shift is floor; value fits when all bits above 31 match the sign
	always_comb begin
		logic signed [ACC_W-1:0]     shifted;
		logic [ACC_W-DATA_W:0]       top;
		for (int c = 0; c < NCOMP; c++) begin
			shifted = $signed(total_s3[c]) >>> FRAC_BITS;
			top     = shifted[ACC_W-1:DATA_W-1];
			over[c] = !((&top) || !(|top));
			if (!over[c]) begin
				clip[c] = shifted[DATA_W-1:0];
			end else if (shifted[ACC_W-1]) begin
				clip[c] = SAT_MIN;
			end else begin
				clip[c] = SAT_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		result_s4.r_x       <= clip[CX];
		result_s4.r_y       <= clip[CY];
		result_s4.r_z       <= clip[CZ];
		result_s4.r_w       <= clip[CW];
		result_s4.saturated <= |over;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

endmodule

// ===== hdl/quaternion_product.sv =====
// Hamilton quaternion product in signed Q16.16, round to nearest, saturating.
// Throughput: one beat per cycle while busy is low; four register stages
// (multiply, pair add, total add, clamp) with no stall path, since the
// receiver cannot hold off.
// Reset clears the stage valid bits; busy is high only during reset and
// the first cycle after release.
module quaternion_product (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  qp_pkg::qp_in_t  operand,
	output logic            done,
	output qp_pkg::qp_out_t result
);
	import qp_pkg::*;

	logic      busy_q;
	logic      accept;
	logic      valid_s1;
	logic      valid_s3;
	prod_set_t prod_s1;
	acc_set_t  total_s3;

	// hold off input only while coming out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	qp_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.operand  (operand),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1)
	);

	qp_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1),
		.valid_s3 (valid_s3),
		.total_s3 (total_s3)
	);

	qp_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.total_s3  (total_s3),
		.valid_s4  (done),
		.result_s4 (result)
	);

endmodule

// ===== hdl/qp_chk.sv =====
// Port-level checker for quaternion_product, bound to the top level.
// Depends on qp_pkg and quaternion_product_assert.svh.
`include "quaternion_product_assert.svh"

module qp_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input qp_pkg::qp_in_t  operand,
	input logic            done,
	input qp_pkg::qp_out_t result
);
	import qp_pkg::*;

	logic take;
	logic p_zero;
	logic clipped;

	assign take    = start && !busy;
	assign p_zero  = (operand.p_x == '0) && (operand.p_y == '0) &&
		(operand.p_z == '0) && (operand.p_w == '0);
	assign clipped = (result.r_x == SAT_MAX) || (result.r_x == SAT_MIN) ||
		(result.r_y == SAT_MAX) || (result.r_y == SAT_MIN) ||
		(result.r_z == SAT_MAX) || (result.r_z == SAT_MIN) ||
		(result.r_w == SAT_MAX) || (result.r_w == SAT_MIN);

	// every beat taken comes out after the pipeline depth
	`QP_ASSERT_DLY(a_beat_out, clk, arst_n, take, LATENCY, done, "accepted beat lost")
	// no result without a beat taken the pipeline depth earlier
	`QP_ASSERT_IMP(a_no_ghost, clk, arst_n, done, $past(take, LATENCY), "result without beat")
	// a zero left operand gives an exact zero product
	`QP_ASSERT_DLY(a_zero_prod, clk, arst_n, take && p_zero, LATENCY,
		(result == '0), "zero operand gave nonzero result")
	// the clip flag only ever comes with a component at a range limit
	`QP_ASSERT_IMP(a_sat_limit, clk, arst_n, done && result.saturated, clipped,
		"saturation flag without clipped component")

endmodule

bind quaternion_product qp_chk u_chk (.*);
